>>> src/bptc_pkg.sv
package bptc_pkg;

  // Field and coefficient widths
  localparam int RAW_W   = 24;
  localparam int COEF_W  = 16;
  localparam int TEMP_W  = 19;
  localparam int PRES_W  = 32;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  // Internal datapath widths
  localparam int DT_W    = RAW_W + 1;              // signed temperature difference
  localparam int MUL_W   = DT_W + COEF_W + 1;      // dT times a coefficient
  localparam int DSQ_W   = 2 * DT_W;               // dT squared
  localparam int T2_W    = 18;                     // dT^2 >> 31 stays below 2^17
  localparam int SQ_W    = 35;                     // (TEMP-2000)^2 and (TEMP+1500)^2
  localparam int CORR_W  = 38;                     // OFF2 and SENS2
  localparam int OFF_W   = 41;                     // OFF and SENS, signed
  localparam int HI_W    = OFF_W - RAW_W;          // upper slice of SENS for the split product
  localparam int PL_W    = 2 * RAW_W;              // low partial product
  localparam int PH_W    = RAW_W + 1 + HI_W;       // high partial product, signed
  localparam int PROD_W  = PH_W + RAW_W;           // full D1 * SENS
  localparam int X_W     = PROD_W - 21;            // D1 * SENS >> 21
  localparam int DIFF_W  = X_W + 1;

  // Shift amounts of the compensation formulas
  localparam int TEMP_SH      = 23;
  localparam int T2_SH        = 31;
  localparam int OFF_SH       = 7;
  localparam int SENS_SH      = 8;
  localparam int OFF_BASE_SH  = 16;
  localparam int SENS_BASE_SH = 15;
  localparam int PROD_SH      = 21;
  localparam int PRES_SH      = 15;

  // Temperature constants in hundredths of a degree
  localparam logic signed [TEMP_W-1:0] TEMP_REF      = 19'sd2000;
  localparam logic signed [TEMP_W-1:0] TEMP_COLD_OFS = 19'sd3500;   // 2000 + 1500

  // Cycles from an accepted start to the result strobe
  localparam int LATENCY = 9;

  // Register indexes
  localparam logic [2:0] REG_C1 = 3'd0;
  localparam logic [2:0] REG_C2 = 3'd1;
  localparam logic [2:0] REG_C3 = 3'd2;
  localparam logic [2:0] REG_C4 = 3'd3;
  localparam logic [2:0] REG_C5 = 3'd4;
  localparam logic [2:0] REG_C6 = 3'd5;

  typedef struct packed {
    logic [COEF_W-1:0] c1;
    logic [COEF_W-1:0] c2;
    logic [COEF_W-1:0] c3;
    logic [COEF_W-1:0] c4;
    logic [COEF_W-1:0] c5;
    logic [COEF_W-1:0] c6;
  } bptc_coef_t;

  typedef struct packed {
    logic              valid;
    logic [RAW_W-1:0]  d1;
    logic [TEMP_W-1:0] tc;
    logic [OFF_W-1:0]  off;
    logic [OFF_W-1:0]  sens;
  } bptc_mid_t;

endpackage

>>> src/baro_pressure_temp_compensation_unit.sv
// Channel   Handshake                          Payload
// input     start (accepted while busy low)    in_raw_temperature, in_raw_pressure
// result    out_valid, one cycle, no stall     out_temperature_centi, out_pressure_pa
// config    psel/penable/pwrite, pready high   paddr, pwdata, prdata
//
// A sample pair may enter on every cycle; busy is never raised.
// Each result is carried through the nine register
// stages of the multiplier pipeline (dT products, squares, split D1 * SENS).
// Reset is synchronous and active low; it clears the coefficients and the
// valid bits, so samples in flight are dropped.
// Coefficients are read by the dT, product and scaling stages, so write them only while the pipe is empty.
module baro_pressure_temp_compensation_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [bptc_pkg::RAW_W-1:0]          in_raw_temperature,
  input  logic [bptc_pkg::RAW_W-1:0]          in_raw_pressure,
  output logic                                out_valid,
  output logic signed [bptc_pkg::TEMP_W-1:0]  out_temperature_centi,
  output logic signed [bptc_pkg::PRES_W-1:0]  out_pressure_pa,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bptc_pkg::ADDR_W-1:0]         paddr,
  input  logic [bptc_pkg::DATA_W-1:0]         pwdata,
  output logic [bptc_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);
  import bptc_pkg::*;

  bptc_coef_t coef;
  bptc_mid_t  mid;
  logic       take;

  // Fully pipelined, so never hold off a transfer
  assign busy = 1'b0;
  assign take = start && !busy;

  bptc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef    (coef)
  );

  bptc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_take (take),
    .in_d2   (in_raw_temperature),
    .in_d1   (in_raw_pressure),
    .coef    (coef),
    .mid     (mid)
  );

  bptc_press u_press (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .mid                   (mid),
    .out_valid             (out_valid),
    .out_temperature_centi (out_temperature_centi),
    .out_pressure_pa       (out_pressure_pa)
  );

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> ##LATENCY out_valid)
    else $error("accepted sample produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(take, LATENCY))
    else $error("result without a matching accepted sample");

endmodule

>>> src/bptc_regs.sv
module bptc_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bptc_pkg::ADDR_W-1:0]  paddr,
  input  logic [bptc_pkg::DATA_W-1:0]  pwdata,
  output logic [bptc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output bptc_pkg::bptc_coef_t         coef
);
  import bptc_pkg::*;

  bptc_coef_t coef_r;
  bptc_coef_t coef_nxt;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:2];
  assign coef   = coef_r;

  // Decode the write transfer into one coefficient
  always_comb begin
    coef_nxt = coef_r;
    if (wr_en) begin
      case (idx)
        REG_C1:  coef_nxt.c1 = pwdata[COEF_W-1:0];
        REG_C2:  coef_nxt.c2 = pwdata[COEF_W-1:0];
        REG_C3:  coef_nxt.c3 = pwdata[COEF_W-1:0];
        REG_C4:  coef_nxt.c4 = pwdata[COEF_W-1:0];
        REG_C5:  coef_nxt.c5 = pwdata[COEF_W-1:0];
        REG_C6:  coef_nxt.c6 = pwdata[COEF_W-1:0];
        default: coef_nxt = coef_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  // Return the addressed coefficient on a read
  always_comb begin
    case (idx)
      REG_C1:  prdata = {{(DATA_W-COEF_W){1'b0}}, coef_r.c1};
      REG_C2:  prdata = {{(DATA_W-COEF_W){1'b0}}, coef_r.c2};
      REG_C3:  prdata = {{(DATA_W-COEF_W){1'b0}}, coef_r.c3};
      REG_C4:  prdata = {{(DATA_W-COEF_W){1'b0}}, coef_r.c4};
      REG_C5:  prdata = {{(DATA_W-COEF_W){1'b0}}, coef_r.c5};
      REG_C6:  prdata = {{(DATA_W-COEF_W){1'b0}}, coef_r.c6};
      default: prdata = '0;
    endcase
  end

  a_wr_c5: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && (idx == REG_C5) |=> coef_r.c5 == $past(pwdata[COEF_W-1:0]))
    else $error("reference temperature write not taken");

  a_wr_unused: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && (idx > REG_C6) |=> $stable(coef_r))
    else $error("write to unused address changed a coefficient");

endmodule

>>> src/bptc_front.sv
module bptc_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_take,
  input  logic [bptc_pkg::RAW_W-1:0]  in_d2,
  input  logic [bptc_pkg::RAW_W-1:0]  in_d1,
  input  bptc_pkg::bptc_coef_t        coef,
  output bptc_pkg::bptc_mid_t         mid
);
  import bptc_pkg::*;

  // Stage 1: temperature difference
  logic                     v1_r;
  logic signed [DT_W-1:0]   dt1_r;
  logic [RAW_W-1:0]         d1_1_r;
  logic signed [DT_W-1:0]   dt1_nxt;

  // Stage 2: products of dT
  logic                     v2_r;
  logic signed [MUL_W-1:0]  mt2_r;
  logic signed [MUL_W-1:0]  moff2_r;
  logic signed [MUL_W-1:0]  msens2_r;
  logic signed [DSQ_W-1:0]  dsq2_r;
  logic [RAW_W-1:0]         d1_2_r;
  logic signed [MUL_W-1:0]  mt2_nxt;
  logic signed [MUL_W-1:0]  moff2_nxt;
  logic signed [MUL_W-1:0]  msens2_nxt;
  logic signed [DSQ_W-1:0]  dsq2_nxt;

  // Stage 3: first-order temperature, offset and sensitivity
  logic                     v3_r;
  logic signed [TEMP_W-1:0] a3_r;
  logic signed [TEMP_W-1:0] b3_r;
  logic signed [TEMP_W-1:0] temp3_r;
  logic [T2_W-1:0]          t2_3_r;
  logic                     low3_r;
  logic                     cold3_r;
  logic signed [OFF_W-1:0]  off3_r;
  logic signed [OFF_W-1:0]  sens3_r;
  logic [RAW_W-1:0]         d1_3_r;
  logic signed [TEMP_W-1:0] a3_nxt;
  logic signed [TEMP_W-1:0] b3_nxt;
  logic signed [TEMP_W-1:0] temp3_nxt;
  logic signed [OFF_W-1:0]  off3_nxt;
  logic signed [OFF_W-1:0]  sens3_nxt;

  // Stage 4: squares and corrected temperature
  logic                     v4_r;
  logic [SQ_W-1:0]          sqa4_r;
  logic [SQ_W-1:0]          sqb4_r;
  logic                     low4_r;
  logic                     cold4_r;
  logic signed [TEMP_W-1:0] tc4_r;
  logic signed [OFF_W-1:0]  off4_r;
  logic signed [OFF_W-1:0]  sens4_r;
  logic [RAW_W-1:0]         d1_4_r;
  logic signed [2*TEMP_W-1:0] sqa4_nxt;
  logic signed [2*TEMP_W-1:0] sqb4_nxt;
  logic signed [TEMP_W-1:0] tc4_nxt;

  // Stage 5: second-order corrections
  logic                     v5_r;
  logic                     low5_r;
  logic [CORR_W-1:0]        off2_5_r;
  logic [CORR_W-1:0]        sens2_5_r;
  logic signed [TEMP_W-1:0] tc5_r;
  logic signed [OFF_W-1:0]  off5_r;
  logic signed [OFF_W-1:0]  sens5_r;
  logic [RAW_W-1:0]         d1_5_r;
  logic [SQ_W+1:0]          a5x;
  logic [CORR_W-1:0]        b7;
  logic [CORR_W-1:0]        b11;
  logic [CORR_W-1:0]        off2_5_nxt;
  logic [CORR_W-1:0]        sens2_5_nxt;

  // Stage 6: corrected offset and sensitivity
  logic                     v6_r;
  logic signed [TEMP_W-1:0] tc6_r;
  logic signed [OFF_W-1:0]  off6_r;
  logic signed [OFF_W-1:0]  sens6_r;
  logic [RAW_W-1:0]         d1_6_r;
  logic signed [OFF_W-1:0]  off6_nxt;
  logic signed [OFF_W-1:0]  sens6_nxt;

  // Subtract the reference temperature, C5 shifted up a byte
  assign dt1_nxt = {1'b0, in_d2} - {1'b0, coef.c5, 8'h00};

  // Multiply dT by C6, C4, C3 and itself
  always_comb begin
    mt2_nxt    = dt1_r * $signed({1'b0, coef.c6});
    moff2_nxt  = dt1_r * $signed({1'b0, coef.c4});
    msens2_nxt = dt1_r * $signed({1'b0, coef.c3});
    dsq2_nxt   = dt1_r * dt1_r;
  end

  // Scale the products; a is TEMP - 2000 and b is TEMP + 1500
  always_comb begin
    a3_nxt    = mt2_r[MUL_W-1:TEMP_SH];
    temp3_nxt = TEMP_REF + a3_nxt;
    b3_nxt    = a3_nxt + TEMP_COLD_OFS;
    off3_nxt  = $signed({{(OFF_W-COEF_W-OFF_BASE_SH){1'b0}}, coef.c2, {OFF_BASE_SH{1'b0}}})
              + $signed({{(OFF_W-MUL_W+OFF_SH){moff2_r[MUL_W-1]}}, moff2_r[MUL_W-1:OFF_SH]});
    sens3_nxt = $signed({{(OFF_W-COEF_W-SENS_BASE_SH){1'b0}}, coef.c1,
                         {SENS_BASE_SH{1'b0}}})
              + $signed({{(OFF_W-MUL_W+SENS_SH){msens2_r[MUL_W-1]}},
                         msens2_r[MUL_W-1:SENS_SH]});
  end

  // Square both temperature distances; apply T2 below 20 C
  always_comb begin
    sqa4_nxt = a3_r * a3_r;
    sqb4_nxt = b3_r * b3_r;
    tc4_nxt  = temp3_r - (low3_r ? $signed({{(TEMP_W-T2_W){1'b0}}, t2_3_r})
                                  : $signed({TEMP_W{1'b0}}));
  end

  // Build OFF2 and SENS2 from shift-and-add constant products
  always_comb begin
    a5x = {sqa4_r, 2'b00} + {2'b00, sqa4_r};
    b7  = {sqb4_r, 3'b000} - {3'b000, sqb4_r};
    b11 = {sqb4_r, 3'b000} + {2'b00, sqb4_r, 1'b0} + {3'b000, sqb4_r};
    off2_5_nxt  = '0;
    sens2_5_nxt = '0;
    if (low4_r) begin
      off2_5_nxt  = {2'b00, a5x[SQ_W+1:1]};
      sens2_5_nxt = {3'b000, a5x[SQ_W+1:2]};
      if (cold4_r) begin
        off2_5_nxt  = off2_5_nxt + b7;
        sens2_5_nxt = sens2_5_nxt + {1'b0, b11[CORR_W-1:1]};
      end
    end
  end

  // Take the corrections off
  always_comb begin
    off6_nxt  = off5_r  - $signed({{(OFF_W-CORR_W){1'b0}}, off2_5_r});
    sens6_nxt = sens5_r - $signed({{(OFF_W-CORR_W){1'b0}}, sens2_5_r});
  end

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v1_r <= in_take;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  // Advance the payload
  always_ff @(posedge clk) begin
    dt1_r     <= dt1_nxt;
    d1_1_r    <= in_d1;

    mt2_r     <= mt2_nxt;
    moff2_r   <= moff2_nxt;
    msens2_r  <= msens2_nxt;
    dsq2_r    <= dsq2_nxt;
    d1_2_r    <= d1_1_r;

    a3_r      <= a3_nxt;
    b3_r      <= b3_nxt;
    temp3_r   <= temp3_nxt;
    t2_3_r    <= dsq2_r[T2_SH+T2_W-1:T2_SH];
    low3_r    <= a3_nxt[TEMP_W-1];
    cold3_r   <= b3_nxt[TEMP_W-1];
    off3_r    <= off3_nxt;
    sens3_r   <= sens3_nxt;
    d1_3_r    <= d1_2_r;

    sqa4_r    <= sqa4_nxt[SQ_W-1:0];
    sqb4_r    <= sqb4_nxt[SQ_W-1:0];
    low4_r    <= low3_r;
    cold4_r   <= cold3_r;
    tc4_r     <= tc4_nxt;
    off4_r    <= off3_r;
    sens4_r   <= sens3_r;
    d1_4_r    <= d1_3_r;

    low5_r    <= low4_r;
    off2_5_r  <= off2_5_nxt;
    sens2_5_r <= sens2_5_nxt;
    tc5_r     <= tc4_r;
    off5_r    <= off4_r;
    sens5_r   <= sens4_r;
    d1_5_r    <= d1_4_r;

    tc6_r     <= tc5_r;
    off6_r    <= off6_nxt;
    sens6_r   <= sens6_nxt;
    d1_6_r    <= d1_5_r;
  end

  always_comb begin
    mid.valid = v6_r;
    mid.d1    = d1_6_r;
    mid.tc    = tc6_r;
    mid.off   = off6_r;
    mid.sens  = sens6_r;
  end

  a_cold_is_low: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && cold3_r |-> low3_r)
    else $error("below -15 C flagged without the below 20 C branch");

  a_warm_no_corr: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r && !low5_r |-> (off2_5_r == '0) && (sens2_5_r == '0))
    else $error("second-order correction applied above 20 C");

endmodule

>>> src/bptc_press.sv
module bptc_press (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bptc_pkg::bptc_mid_t                 mid,
  output logic                                out_valid,
  output logic signed [bptc_pkg::TEMP_W-1:0]  out_temperature_centi,
  output logic signed [bptc_pkg::PRES_W-1:0]  out_pressure_pa
);
  import bptc_pkg::*;

  // Stage 7: split product of D1 and SENS
  logic                     v7_r;
  logic [PL_W-1:0]          pl7_r;
  logic signed [PH_W-1:0]   ph7_r;
  logic signed [OFF_W-1:0]  off7_r;
  logic [TEMP_W-1:0]        tc7_r;
  logic signed [PH_W-1:0]   ph7_nxt;

  // Stage 8: recombined product, scaled
  logic                     v8_r;
  logic signed [X_W-1:0]    x8_r;
  logic signed [OFF_W-1:0]  off8_r;
  logic [TEMP_W-1:0]        tc8_r;
  logic signed [PROD_W-1:0] prod8_nxt;

  // Stage 9: result register
  logic                     out_valid_r;
  logic signed [TEMP_W-1:0] temp_r;
  logic signed [PRES_W-1:0] pres_r;
  logic signed [DIFF_W-1:0] diff9_nxt;
  logic signed [PRES_W-1:0] pres_nxt;

  // Low partial product is unsigned, high one carries the sign of SENS
  assign ph7_nxt = $signed({1'b0, mid.d1}) * $signed(mid.sens[OFF_W-1:RAW_W]);

  assign prod8_nxt = $signed({ph7_r, {RAW_W{1'b0}}}) + $signed({{(PROD_W-PL_W){1'b0}}, pl7_r});

  // |D1 * SENS >> 21 - OFF| stays below 2^44, so P fits in 31 bits and the
  // 32-bit clamp can never engage; sign-extend straight into the result
  always_comb begin
    diff9_nxt = $signed({x8_r[X_W-1], x8_r})
              - $signed({{(DIFF_W-OFF_W){off8_r[OFF_W-1]}}, off8_r});
    pres_nxt  = {{(PRES_W-DIFF_W+PRES_SH){diff9_nxt[DIFF_W-1]}}, diff9_nxt[DIFF_W-1:PRES_SH]};
  end

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r        <= 1'b0;
      v8_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v7_r        <= mid.valid;
      v8_r        <= v7_r;
      out_valid_r <= v8_r;
    end
  end

  // Advance the payload
  always_ff @(posedge clk) begin
    pl7_r  <= mid.d1 * mid.sens[RAW_W-1:0];
    ph7_r  <= ph7_nxt;
    off7_r <= $signed(mid.off);
    tc7_r  <= mid.tc;

    x8_r   <= prod8_nxt[PROD_W-1:PROD_SH];
    off8_r <= off7_r;
    tc8_r  <= tc7_r;

    temp_r <= $signed(tc8_r);
    pres_r <= pres_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_temperature_centi = temp_r;
  assign out_pressure_pa       = pres_r;

endmodule
